// ===== sv/swtm_pkg.sv =====
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared constants, register indexes, controller states and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package swtm_pkg;

	// default sizing
	localparam int WINDOW_MAX_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// configuration register layout
	localparam int WL_BITS      = 9;
	localparam int TC_BITS      = 7;
	localparam int CFG_BITS     = 9;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TRIM_COUNT    = 1'd1;

	localparam logic [WL_BITS-1:0] WL_RESET = 9'd8;
	localparam logic [TC_BITS-1:0] TC_RESET = 7'd2;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_PASS,
		S_DIV,
		S_DONE
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;     // input transfer this cycle
		logic pass;       // merge pass over the sorted copy
		logic div_start;  // load the divider
		logic div_step;   // one quotient bit
		logic emit;       // load the result register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pass_done;
		logic full_after;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== sv/swtm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swtm_ctrl
// Sequencer: accept a sample, run the sorted-merge pass, run the divider
// when the window is full, then hand the result to the output register.
// ----------------------------------------------------------------------------
module swtm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  swtm_pkg::dp_status_t status,
	output swtm_pkg::dp_cmd_t    cmd
);
	import swtm_pkg::*;

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_PASS;
			end
			S_PASS: begin
				if (status.pass_done) state_d = status.full_after ? S_DIV : S_DONE;
			end
			S_DIV: begin
				if (status.div_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_PASS: begin
				cmd.pass      = 1'b1;
				cmd.div_start = status.pass_done & status.full_after;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_DONE: begin
				cmd.emit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free) else $error("emit while output busy");
	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.pass, cmd.div_step, cmd.emit}))
		else $error("overlapping phases");
	a_accept_to_pass: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.pass) else $error("pass did not follow transfer");
`endif

endmodule

// ===== sv/swtm_datapath.sv =====
// ----------------------------------------------------------------------------
// swtm_datapath
// Config registers, sample ring, ping-pong sorted copy with a one-pass
// merge (drop oldest, insert newest, sum middle ranks), restoring divider
// and the result register.
// ----------------------------------------------------------------------------
module swtm_datapath #(
	parameter int WINDOW_MAX  = swtm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swtm_pkg::dp_cmd_t                 cmd,
	output swtm_pkg::dp_status_t              status,
	input  logic                              cfg_we,
	input  logic [swtm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [swtm_pkg::CFG_BITS-1:0]     cfg_data,
	input  logic [SAMPLE_BITS-1:0]            sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [SAMPLE_BITS-1:0]            trimmed_average,
	output logic                              window_full
);
	import swtm_pkg::*;

	localparam int AW = $clog2(WINDOW_MAX);
	localparam int MW = $clog2(WINDOW_MAX + 1);
	localparam int CW = (MW > WL_BITS) ? MW : WL_BITS;
	localparam int KW = (MW > TC_BITS + 1) ? MW : TC_BITS + 1;
	localparam int SW = SAMPLE_BITS + AW;
	localparam int NW = $clog2(SW + 1);

	// config and window bookkeeping
	logic [WL_BITS-1:0]     wl_q;
	logic [TC_BITS-1:0]     tc_q;
	logic [AW-1:0]          wp_q;
	logic [MW-1:0]          seen_q;

	// per-item registers
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] old_q;
	logic                   rmv_q;
	logic                   ins_q;
	logic                   full_after_q;
	logic [MW-1:0]          n_in_q;
	logic [MW-1:0]          n_out_q;
	logic [MW-1:0]          r_q, r_d;
	logic [MW-1:0]          w_q;
	logic                   sel_q;
	logic [SAMPLE_BITS-1:0] rdata_q;
	logic [SW-1:0]          acc_q;

	// divider
	logic [SW-1:0]          dq_q;
	logic [MW-1:0]          part_q;
	logic [NW-1:0]          cnt_q;

	// result register
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic                   full_q;

	// memories
	logic [SAMPLE_BITS-1:0] ring  [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] bank0 [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] bank1 [WINDOW_MAX];

	// effective window length and trim
	logic [CW-1:0]          wl_x;
	logic [MW-1:0]          m_eff;
	logic [TC_BITS-1:0]     k_eff;
	logic [MW-1:0]          k_m;
	logic [MW-1:0]          hi_m;
	logic [MW-1:0]          divisor;

	always_comb begin
		wl_x = CW'(wl_q);
		if (wl_x < CW'(3)) wl_x = CW'(3);
		else if (wl_x > CW'(WINDOW_MAX)) wl_x = CW'(WINDOW_MAX);
		m_eff = MW'(wl_x);
		if ((KW'(tc_q) << 1) >= KW'(m_eff)) k_eff = TC_BITS'((m_eff - MW'(1)) >> 1);
		else k_eff = tc_q;
		k_m     = MW'(k_eff);
		hi_m    = m_eff - k_m;
		divisor = m_eff - (k_m << 1);
	end

	// merge decision for the entry under the read pointer
	logic                   x_valid;
	logic                   skip;
	logic                   put_new;
	logic                   put_old;
	logic                   pass_done;
	logic                   wr_en;
	logic [SAMPLE_BITS-1:0] wr_data;
	logic                   full_before;

	always_comb begin
		full_before = (seen_q == m_eff);
		pass_done   = (w_q == n_out_q);
		x_valid     = (r_q < n_in_q);
		skip        = rmv_q && x_valid && (rdata_q == old_q);
		put_new     = !skip && ins_q && (!x_valid || (rdata_q > sample_q));
		put_old     = !skip && !put_new && x_valid;
		wr_en       = cmd.pass && !pass_done && (put_new || put_old);
		wr_data     = put_new ? sample_q : rdata_q;
		if (cmd.accept) r_d = '0;
		else if (cmd.pass && !pass_done && (skip || put_old)) r_d = r_q + MW'(1);
		else r_d = r_q;
	end

	// ring and sorted banks
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			old_q      <= ring[wp_q];
			sample_q   <= sample;
			ring[wp_q] <= sample;
		end
		if (wr_en && sel_q)  bank0[w_q[AW-1:0]] <= wr_data;
		if (wr_en && !sel_q) bank1[w_q[AW-1:0]] <= wr_data;
		rdata_q <= sel_q ? bank1[r_d[AW-1:0]] : bank0[r_d[AW-1:0]];
	end

	// config, bookkeeping and merge control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q         <= WL_RESET;
			tc_q         <= TC_RESET;
			wp_q         <= '0;
			seen_q       <= '0;
			sel_q        <= 1'b0;
			rmv_q        <= 1'b0;
			ins_q        <= 1'b0;
			full_after_q <= 1'b0;
			n_in_q       <= '0;
			n_out_q      <= '0;
			r_q          <= '0;
			w_q          <= '0;
		end else begin
			r_q <= r_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_LENGTH: wl_q <= cfg_data[WL_BITS-1:0];
					REG_TRIM_COUNT:    tc_q <= cfg_data[TC_BITS-1:0];
					default:           wl_q <= wl_q;
				endcase
				wp_q   <= '0;
				seen_q <= '0;
			end else if (cmd.accept) begin
				wp_q         <= (MW'(wp_q) == m_eff - MW'(1)) ? '0 : wp_q + AW'(1);
				rmv_q        <= full_before;
				ins_q        <= 1'b1;
				n_in_q       <= seen_q;
				n_out_q      <= full_before ? m_eff : seen_q + MW'(1);
				seen_q       <= full_before ? seen_q : seen_q + MW'(1);
				full_after_q <= full_before || (seen_q + MW'(1) == m_eff);
				w_q          <= '0;
			end
			if (cmd.pass && !pass_done) begin
				if (skip) rmv_q <= 1'b0;
				if (put_new) ins_q <= 1'b0;
				if (wr_en) w_q <= w_q + MW'(1);
			end
			if (cmd.pass && pass_done) sel_q <= ~sel_q;
		end
	end

	// middle-rank sum and divider
	logic [MW:0] shifted;
	logic        ge;

	always_comb begin
		shifted = {part_q, dq_q[SW-1]};
		ge      = (shifted >= {1'b0, divisor});
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			acc_q <= '0;
		end else if (wr_en && full_after_q && (w_q >= k_m) && (w_q < hi_m)) begin
			acc_q <= acc_q + SW'(wr_data);
		end
		if (cmd.div_start) begin
			dq_q   <= acc_q;
			part_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			part_q <= ge ? MW'(shifted - {1'b0, divisor}) : MW'(shifted);
			dq_q   <= {dq_q[SW-2:0], ge};
			cnt_q  <= cnt_q + NW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			avg_q  <= full_after_q ? dq_q[SAMPLE_BITS-1:0] : '0;
			full_q <= full_after_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign trimmed_average  = avg_q;
	assign window_full      = full_q;
	assign status.pass_done  = pass_done;
	assign status.full_after = full_after_q;
	assign status.div_done   = cmd.div_step && (cnt_q == NW'(SW - 1));
	assign status.out_free   = !out_valid_q || out_ready;

`ifndef NO_ASSERTIONS
	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		w_q <= n_out_q) else $error("merge wrote past window");
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pass |-> r_q <= n_in_q) else $error("merge read past window");
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= m_eff) else $error("sample count above window length");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q) else $error("result not presented");
`endif

endmodule

// ===== sv/sliding_window_trimmed_mean.sv =====
// Sliding-window trimmed mean.
// Input channel (in_valid/in_ready, sample) takes one unsigned sample per
// transfer; output channel (out_valid/out_ready) returns one result per
// sample: trimmed_average and window_full. Until window_length samples
// have arrived, window_full is 0 and the average is 0.
// Config: cfg_we with cfg_index 0 writes window_length, 1 writes
// trim_count; every write empties the window. Write only while idle.
// Sequence: one item at a time. Each input transfer runs a merge pass
// over the sorted entries through the single-port sorted banks and, once
// the window is full, the divider, which yields one quotient bit per cycle;
// the result is then loaded into the output register.
// Handshake: in_ready is high only in the idle state, entered after the
// result is loaded, so the block takes no new sample until the result of
// the current one has been loaded.
// Reset: config returns to length 8, trim 2, window empty; no clearing pass.
// A stalled receiver holds the result register; the block finishes its
// current item and waits for the output before taking the next sample.
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean #(
	parameter int WINDOW_MAX  = swtm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swtm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [swtm_pkg::CFG_BITS-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [SAMPLE_BITS-1:0]            sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [SAMPLE_BITS-1:0]            trimmed_average,
	output logic                              window_full
);
	import swtm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	swtm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	swtm_datapath #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.trimmed_average (trimmed_average),
		.window_full     (window_full)
	);

endmodule

// ===== sim/sliding_window_trimmed_mean_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_test
// Self-checking bench for the sliding-window trimmed mean. A behavioral
// window (ring plus sorted copy) predicts each average; results are checked
// in order against the queue of predicted averages while both channels
// idle at random.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean_test;
	import swtm_pkg::*;

	localparam int WMAX  = 256;
	localparam int SBITS = 16;
	localparam int CYCLE_LIMIT = 2000000;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [SBITS-1:0]        sample;
	logic                    out_valid;
	logic                    out_ready;
	logic [SBITS-1:0]        trimmed_average;
	logic                    window_full;

	typedef struct {
		logic [SBITS-1:0] avg;
		logic             full;
	} mean_result_t;

	sliding_window_trimmed_mean uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.trimmed_average(trimmed_average), .window_full(window_full)
	);

	// predictor state
	logic [WL_BITS-1:0] win_len_reg;
	logic [TC_BITS-1:0] trim_reg;
	logic [SBITS-1:0]   ring_q[WMAX];
	logic [SBITS-1:0]   sorted_q[$];
	int                 ring_pos;
	int                 seen;
	mean_result_t       pending_means[$];

	int  errors;
	int  cycles;
	int  items_sent;
	int  results_seen;
	int  full_results;
	bit  calm;  // no idling while set

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic int eff_len();
		int m;
		m = win_len_reg;
		if (m < 3) m = 3;
		if (m > WMAX) m = WMAX;
		return m;
	endfunction

	// update the window with one sample and predict the result
	function automatic mean_result_t predict_mean(logic [SBITS-1:0] s);
		mean_result_t r;
		int m, k, q, p;
		longint mid;
		m = eff_len();
		k = trim_reg;
		if (2 * k >= m) k = (m - 1) / 2;
		if (ring_pos >= m) ring_pos = 0;
		if (seen < m) begin
			seen++;
		end else begin
			p = 0;
			while (sorted_q[p] != ring_q[ring_pos]) p++;
			sorted_q.delete(p);
		end
		q = sorted_q.size();
		while (q > 0 && sorted_q[q-1] > s) q--;
		sorted_q.insert(q, s);
		ring_q[ring_pos] = s;
		ring_pos = (ring_pos + 1 >= m) ? 0 : ring_pos + 1;
		r.avg = '0;
		r.full = 1'b0;
		if (seen >= m) begin
			mid = 0;
			for (int i = k; i < m - k; i++) mid += sorted_q[i];
			r.avg = SBITS'(mid / (m - 2 * k));
			r.full = 1'b1;
		end
		return r;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 16);
	endfunction

	// output side: random stall, compare each transfer with oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				mean_result_t e;
				results_seen++;
				if (pending_means.size() == 0) begin
					$error("result with nothing expected: avg %0d", trimmed_average);
					errors++;
				end else begin
					e = pending_means.pop_front();
					if (window_full) full_results++;
					if (trimmed_average !== e.avg) begin
						$error("trimmed_average expected %0d actual %0d", e.avg,
							trimmed_average);
						errors++;
					end
					if (window_full !== e.full) begin
						$error("window_full expected %0d actual %0d", e.full,
							window_full);
						errors++;
					end
				end
			end
			out_ready <= !idle_now();
		end
	end

	// send one sample, holding valid until the transfer
	task automatic send_sample(logic [SBITS-1:0] s);
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		pending_means.insert(pending_means.size(), predict_mean(s));
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (WMAX + 40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_BITS'(val);
		@(posedge clk);
		if (idx == REG_WINDOW_LENGTH) win_len_reg = WL_BITS'(val);
		else trim_reg = TC_BITS'(val);
		ring_pos = 0;
		seen = 0;
		sorted_q.delete();
	endtask

	task automatic set_window(int m, int k);
		drain();
		write_reg(REG_WINDOW_LENGTH, m);
		write_reg(REG_TRIM_COUNT, k);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SBITS-1:0] rand_sample();
		case ($urandom_range(3))
			0: return SBITS'($urandom_range(7));
			1: return {SBITS{1'b1}} - SBITS'($urandom_range(3));
			default: return SBITS'($urandom);
		endcase
	endfunction

	// defaults after reset: extremes, ties, wrap of the ring
	task automatic test_reset_defaults();
		logic [SBITS-1:0] pat[12] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
			16'h7FFF, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h5555, 16'h0000,
			16'hFFFF};
		foreach (pat[i]) send_sample(pat[i]);
	endtask

	// clamped lengths, zero and oversized trims, full-width write data
	task automatic test_register_edges();
		set_window(0, 0);
		repeat (5) send_sample(rand_sample());
		set_window(511, 127);
		repeat (4) send_sample(rand_sample());
		set_window(3, 1);
		repeat (4) send_sample(rand_sample());
		set_window(4, 2);
		repeat (5) send_sample(16'hFFFF);
	endtask

	// random traffic across several settings, largest window last
	task automatic test_random_windows();
		int settings[6][2] = '{'{5, 0}, '{16, 3}, '{7, 3}, '{32, 15}, '{10, 1},
			'{256, 100}};
		foreach (settings[s]) begin
			set_window(settings[s][0], settings[s][1]);
			calm = (s == 1);
			repeat (s == 5 ? 300 : 45) send_sample(rand_sample());
		end
		calm = 1'b0;
	endtask

	initial begin
		errors = 0; cycles = 0; items_sent = 0; results_seen = 0; full_results = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; sample = '0; out_ready = 1'b0;
		win_len_reg = WL_RESET; trim_reg = TC_RESET;
		ring_pos = 0; seen = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_edges();
		test_random_windows();
		drain();
		$display("%0d samples sent, %0d results checked (%0d with a full window)",
			items_sent, results_seen, full_results);
		$display("windows 3..256 with trims 0..clamped, both sides stalling");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
